>>> hw/rtl/gsfe_pkg.sv
// Package with the types, constants and helper functions of the GGA field extractor.
`default_nettype none

package gsfe_pkg;

    localparam int unsigned HDR_LEN = 7;

    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;

    localparam logic [3:0] FIELD_NONE    = 4'd0;
    localparam logic [3:0] FIELD_TIME    = 4'd1;
    localparam logic [3:0] FIELD_LAT_DIR = 4'd3;
    localparam logic [3:0] FIELD_LON_DIR = 4'd5;
    localparam logic [3:0] FIELD_ALT     = 4'd9;
    localparam logic [3:0] FIELD_GEOID   = 4'd10;
    localparam logic [3:0] COMMA_GEOID   = 4'd11;
    localparam logic [3:0] COMMA_MAX     = 4'd15;

    localparam logic [1:0] HEX_CLOSED = 2'd3;

    typedef struct packed {
        logic [3:0] field_code;
        logic [7:0] field_char;
        logic [3:0] char_position;
        logic       char_valid;
        logic       field_overflow;
        logic       sentence_done;
        logic       header_match;
        logic       checksum_ok;
    } result_t;

    typedef struct packed {
        logic hex_ok;
        logic [3:0] value;
    } hex_digit_t;

    function automatic logic [7:0] header_char(input logic [2:0] idx);
        logic [7:0] c;
        begin
            case (idx)
                3'd0:    c = 8'h24;
                3'd1:    c = 8'h47;
                3'd2:    c = 8'h50;
                3'd3:    c = 8'h47;
                3'd4:    c = 8'h47;
                3'd5:    c = 8'h41;
                3'd6:    c = 8'h2C;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t h;
        begin
            h.hex_ok = 1'b1;
            h.value  = 4'd0;
            if (c >= 8'h30 && c <= 8'h39) begin
                h.value = 4'(c - 8'h30);
            end else if (c >= 8'h41 && c <= 8'h46) begin
                h.value = 4'(c - 8'h41 + 8'd10);
            end else if (c >= 8'h61 && c <= 8'h66) begin
                h.value = 4'(c - 8'h61 + 8'd10);
            end else begin
                h.hex_ok = 1'b0;
            end
            return h;
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/gsfe_in_if.sv
// Channel interface that carries one sentence byte per beat.
`default_nettype none

interface gsfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/gsfe_out_if.sv
// Channel interface that carries one tagged result per beat.
`default_nettype none

interface gsfe_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] field_code;
    logic [7:0] field_char;
    logic [3:0] char_position;
    logic       char_valid;
    logic       field_overflow;
    logic       sentence_done;
    logic       header_match;
    logic       checksum_ok;

    modport source (
        output valid, output field_code, output field_char, output char_position,
        output char_valid, output field_overflow, output sentence_done,
        output header_match, output checksum_ok, input ready
    );
    modport sink (
        input valid, input field_code, input field_char, input char_position,
        input char_valid, input field_overflow, input sentence_done,
        input header_match, input checksum_ok, output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/gsfe_checksum.sv
// Running XOR of the sentence body and decoding of the transmitted hex checksum.
`default_nettype none

module gsfe_checksum (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    input  wire logic       first_byte,
    output logic            star_seen,
    output logic            checksum_ok
);

    logic [7:0] xor_reg, xor_next;
    logic       star_reg, star_next;
    logic [1:0] taken_reg, taken_next;
    logic [7:0] sum_reg, sum_next;
    gsfe_pkg::hex_digit_t digit;

    assign digit     = gsfe_pkg::hex_decode(data_byte);
    assign star_seen = star_reg;

    always_comb
    begin
        xor_next   = xor_reg;
        star_next  = star_reg;
        taken_next = taken_reg;
        sum_next   = sum_reg;
        if (!star_reg) begin
            if (data_byte == gsfe_pkg::CHAR_STAR) begin
                star_next = 1'b1;
            end else if (!first_byte) begin
                xor_next = xor_reg ^ data_byte;
            end
        end else if (taken_reg < 2'd2) begin
            if (digit.hex_ok) begin
                sum_next   = {sum_reg[3:0], digit.value};
                taken_next = taken_reg + 2'd1;
            end else begin
                taken_next = gsfe_pkg::HEX_CLOSED;
            end
        end
        checksum_ok = last_byte && star_next && (xor_next == sum_next);
        if (last_byte) begin
            xor_next   = 8'd0;
            star_next  = 1'b0;
            taken_next = 2'd0;
            sum_next   = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            xor_reg   <= 8'd0;
            star_reg  <= 1'b0;
            taken_reg <= 2'd0;
            sum_reg   <= 8'd0;
        end else if (step) begin
            xor_reg   <= xor_next;
            star_reg  <= star_next;
            taken_reg <= taken_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/gsfe_field_tagger.sv
// Header match, comma counting and field tagging of each sentence byte.
`default_nettype none

module gsfe_field_tagger #(
    parameter int unsigned MAX_FIELD_CHARS = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    input  wire logic       star_seen,
    output logic            first_byte,
    output gsfe_pkg::result_t tag
);

    localparam int unsigned PW = $clog2(MAX_FIELD_CHARS + 1);
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_FIELD_CHARS);
    localparam logic [2:0] IDX_END = 3'(gsfe_pkg::HDR_LEN);

    logic [2:0]    idx_reg, idx_next;
    logic          hok_reg, hok_next;
    logic [3:0]    cc_reg, cc_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW+3:0] pos_ext;
    logic [3:0]    code;
    logic          is_dir;

    assign first_byte = (idx_reg == 3'd0);
    assign pos_ext    = {4'd0, pos_reg};

    always_comb
    begin
        if (cc_reg >= gsfe_pkg::FIELD_TIME && cc_reg <= gsfe_pkg::FIELD_ALT) begin
            code = cc_reg;
        end else if (cc_reg == gsfe_pkg::COMMA_GEOID) begin
            code = gsfe_pkg::FIELD_GEOID;
        end else begin
            code = gsfe_pkg::FIELD_NONE;
        end
        is_dir = (code == gsfe_pkg::FIELD_LAT_DIR) || (code == gsfe_pkg::FIELD_LON_DIR);
    end

    always_comb
    begin
        idx_next = idx_reg;
        hok_next = hok_reg;
        cc_next  = cc_reg;
        pos_next = pos_reg;
        tag      = '0;
        if (idx_reg < IDX_END) begin
            if (first_byte) begin
                hok_next = (data_byte == gsfe_pkg::header_char(idx_reg));
            end else begin
                hok_next = hok_reg && (data_byte == gsfe_pkg::header_char(idx_reg));
            end
            if (idx_reg == IDX_END - 3'd1 && hok_next) begin
                cc_next = gsfe_pkg::FIELD_TIME;
            end
            idx_next = idx_reg + 3'd1;
        end else if (hok_reg && !star_seen && data_byte != gsfe_pkg::CHAR_STAR) begin
            if (data_byte == gsfe_pkg::CHAR_COMMA) begin
                if (cc_reg < gsfe_pkg::COMMA_MAX) begin
                    cc_next = cc_reg + 4'd1;
                end
                pos_next = '0;
            end else begin
                if (code != gsfe_pkg::FIELD_NONE && !(is_dir && pos_reg != '0)) begin
                    tag.field_code = code;
                    tag.field_char = data_byte;
                    if (pos_reg >= POS_MAX) begin
                        tag.field_overflow = 1'b1;
                    end else begin
                        tag.char_valid    = 1'b1;
                        tag.char_position = pos_ext[3:0];
                    end
                end
                if (pos_reg < POS_MAX) begin
                    pos_next = pos_reg + PW'(1);
                end
            end
        end
        tag.header_match  = hok_next && (idx_next == IDX_END);
        tag.sentence_done = last_byte;
        if (last_byte) begin
            idx_next = 3'd0;
            hok_next = 1'b0;
            cc_next  = 4'd0;
            pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg <= 3'd0;
            hok_reg <= 1'b0;
            cc_reg  <= 4'd0;
            pos_reg <= '0;
        end else if (step) begin
            idx_reg <= idx_next;
            hok_reg <= hok_next;
            cc_reg  <= cc_next;
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/gga_sentence_field_extractor_unit.sv
// Top level of the GGA sentence field extractor with its input and result registers.
`default_nettype none

// The unit takes one sentence byte per beat and returns one result per byte, at a sustained
// rate of one byte per clock cycle while the output is not stalled. A byte is held in the input
// register, then the header, comma and checksum state is updated from it as it moves into the
// result register, which holds its result until it is taken. Field characters are tagged
// for the GGA fields from time to geoid separation, the altitude unit is skipped, and
// characters beyond MAX_FIELD_CHARS in a field are flagged as overflow. The checksum verdict
// is given with the result of the byte marked last, after which all sentence state returns
// to its reset value.
module gga_sentence_field_extractor_unit #(
    parameter int unsigned MAX_FIELD_CHARS = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    gsfe_in_if.sink   sentence,
    gsfe_out_if.source result
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    gsfe_pkg::result_t out_reg, out_next;
    gsfe_pkg::result_t tag;
    logic              advance;
    logic              first_byte;
    logic              star_seen;
    logic              checksum_ok;

    assign advance        = in_valid_reg && (!out_valid_reg || result.ready);
    assign sentence.ready = !in_valid_reg || advance;

    gsfe_field_tagger #(
        .MAX_FIELD_CHARS(MAX_FIELD_CHARS)
    ) u_tagger (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .data_byte  (in_byte_reg),
        .last_byte  (in_last_reg),
        .star_seen  (star_seen),
        .first_byte (first_byte),
        .tag        (tag)
    );

    gsfe_checksum u_checksum (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .data_byte   (in_byte_reg),
        .last_byte   (in_last_reg),
        .first_byte  (first_byte),
        .star_seen   (star_seen),
        .checksum_ok (checksum_ok)
    );

    always_comb
    begin
        out_next             = tag;
        out_next.checksum_ok = checksum_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (sentence.ready) begin
                in_valid_reg <= sentence.valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (result.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sentence.valid && sentence.ready) begin
            in_byte_reg <= sentence.data_byte;
            in_last_reg <= sentence.last_byte;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.field_code     = out_reg.field_code;
    assign result.field_char     = out_reg.field_char;
    assign result.char_position  = out_reg.char_position;
    assign result.char_valid     = out_reg.char_valid;
    assign result.field_overflow = out_reg.field_overflow;
    assign result.sentence_done  = out_reg.sentence_done;
    assign result.header_match   = out_reg.header_match;
    assign result.checksum_ok    = out_reg.checksum_ok;

endmodule

`default_nettype wire
